[rtl/rtpdp_pkg.sv]
`default_nettype none
package rtpdp_pkg;

  localparam int CFG_W      = 13;
  localparam int POS_W      = 16;
  localparam int COUNT_W    = 7;
  localparam int FIELD_W    = 15;
  localparam int OUT_ADDR_W = 25;
  localparam int PROD_W     = 30;  // line*width*2 + offset*2 fits here

  localparam logic [POS_W-1:0]   MARKER_POS     = 16'd1;
  localparam logic [POS_W-1:0]   PAYLOAD_START  = 16'd14;
  localparam logic [POS_W-1:0]   POS_MAX        = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 7'd127;
  localparam int                 MORE_FLAG_BIT  = 15;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET   = 13'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  // byte phase inside a 6-byte line header
  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LINE_HI = 3'd2,
    PH_LINE_LO = 3'd3,
    PH_OFF_HI  = 3'd4,
    PH_OFF_LO  = 3'd5
  } hdr_phase_t;

  typedef enum logic {
    CFG_LINE_WIDTH   = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage
`default_nettype wire

[rtl/rtp_raw_video_depacketizer_core.sv]
`default_nettype none
// RTP raw (uncompressed) video depacketizer.
// in_*  : one UDP payload byte per transaction in network order, in_tlast on the
//         final byte of the datagram. The RTP header and extended sequence number
//         are parsed, then the line headers, then the payload bytes are mapped to
//         frame-store byte addresses.
// out_* : one transaction for each byte that writes the frame store and one for
//         each datagram's final byte. out_tuser[0] marks a valid store write;
//         out_tlast is the frame end (last byte of a marked packet).
// cfg_* : line width and frame height, written while no packet is in flight.
// From the input transaction a byte passes the input register, then the
// parse/address step that feeds the output register. One byte is accepted per
// clock while the receiver takes results; the segment base address (one 15x13
// multiply plus the lookup of the next nonzero segment) is formed in that same step.
// When the receiver stalls with a result waiting, the input register holds and
// in_tready falls in the same cycle; no byte is dropped. Reset (rst_n low,
// synchronous) clears all per-packet state and the pipeline and loads the
// default width 640 and height 480; the segment tables need no reset.
module rtp_raw_video_depacketizer_core #(
  parameter int MAX_SEGMENTS = 8,
  parameter int ADDRESS_BITS = 25
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // packet_last
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [24:0] write_addr, [32:25] write_data, rest 0
  output logic [1:0]       out_tuser,  // [0] write_valid, [1] header_overflow
  output logic             out_tlast,  // frame_end
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [rtpdp_pkg::CFG_W-1:0] cfg_data
);
  import rtpdp_pkg::*;

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CUR_W = $clog2(MAX_SEGMENTS + 1);
  localparam int SUM_W = (ADDRESS_BITS > PROD_W) ? ADDRESS_BITS : PROD_W;
  localparam int MUL_W = FIELD_W + CFG_W;

  // configuration
  logic [CFG_W-1:0] line_width_r, frame_height_r;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // per-packet state
  logic [POS_W-1:0]        pos_r, pos_nxt;
  logic                    marker_r, marker_nxt;
  logic [7:0]              holder_r, holder_nxt;
  logic [COUNT_W-1:0]      count_r, count_nxt;
  logic                    hdone_r, hdone_nxt;
  hdr_phase_t              phase_r, phase_nxt;
  logic [CUR_W-1:0]        cur_r, cur_nxt;
  logic [15:0]             left_r, left_nxt;
  logic [ADDRESS_BITS-1:0] next_addr_r, next_addr_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [FIELD_W-1:0]      cur_line_r, cur_line_nxt;

  // segment tables
  logic [15:0]        len_tab  [MAX_SEGMENTS];
  logic [FIELD_W-1:0] line_tab [MAX_SEGMENTS];
  logic [FIELD_W-1:0] off_tab  [MAX_SEGMENTS];
  logic               len_we, line_we, off_we;
  logic [IDX_W-1:0]   wr_idx;
  logic [15:0]        field_val;

  // output register
  logic                  out_valid_r;
  logic                  o_wr_r, o_wr_nxt;
  logic [OUT_ADDR_W-1:0] o_addr_r, o_addr_nxt;
  logic [7:0]            o_data_r, o_data_nxt;
  logic                  o_fend_r, o_fend_nxt;
  logic                  o_ovf_r, o_ovf_nxt;
  logic                  o_emit;

  logic fire;

  // segment loader
  logic                    load_req;
  logic [CUR_W-1:0]        load_start, load_n;
  logic [MAX_SEGMENTS-1:0] cand;
  logic                    found;
  logic [IDX_W-1:0]        sel;
  logic [FIELD_W-1:0]      sel_line, sel_off;
  logic [MUL_W-1:0]        line_prod;
  logic [SUM_W-1:0]        base_sum;
  logic [CUR_W-1:0]        stored_n;
  logic                    in_hdr_range;
  logic                    wr_hit;
  logic [SUM_W-1:0]        addr_ext;

  assign fire      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || fire;

  assign stored_n = (count_r >= COUNT_W'(MAX_SEGMENTS)) ? CUR_W'(MAX_SEGMENTS)
                                                        : CUR_W'(count_r);
  assign wr_idx    = count_r[IDX_W-1:0];
  assign field_val = {holder_r, s1_byte_r};
  assign in_hdr_range = (pos_r >= PAYLOAD_START) && (pos_r != POS_MAX);

  // first nonzero-length segment at or after load_start
  always_comb begin
    for (int j = 0; j < MAX_SEGMENTS; j++) begin
      cand[j] = (CUR_W'(j) >= load_start) && (CUR_W'(j) < load_n) && (len_tab[j] != '0);
    end
    found = 1'b0;
    sel   = '0;
    for (int j = MAX_SEGMENTS - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found = 1'b1;
        sel   = IDX_W'(j);
      end
    end
  end

  always_comb begin
    sel_line = line_tab[sel];
    // offset of the header finishing this cycle is not in the table yet
    if (off_we && sel == wr_idx) begin
      sel_off = field_val[FIELD_W-1:0];
    end else begin
      sel_off = off_tab[sel];
    end
    line_prod = MUL_W'(sel_line) * MUL_W'(line_width_r);
    base_sum  = SUM_W'({sel_off, 1'b0}) + SUM_W'({line_prod, 1'b0});
  end

  always_comb begin
    pos_nxt       = pos_r;
    marker_nxt    = marker_r;
    holder_nxt    = holder_r;
    count_nxt     = count_r;
    hdone_nxt     = hdone_r;
    phase_nxt     = phase_r;
    cur_nxt       = cur_r;
    left_nxt      = left_r;
    next_addr_nxt = next_addr_r;
    ovf_nxt       = ovf_r;
    cur_line_nxt  = cur_line_r;
    len_we        = 1'b0;
    line_we       = 1'b0;
    off_we        = 1'b0;
    load_req      = 1'b0;
    load_start    = '0;
    load_n        = stored_n;
    wr_hit        = 1'b0;
    o_wr_nxt      = 1'b0;
    o_addr_nxt    = '0;
    o_data_nxt    = '0;
    addr_ext      = SUM_W'(next_addr_r);

    if (!hdone_r) begin
      if (pos_r == MARKER_POS) begin
        marker_nxt = s1_byte_r[7];
      end else if (in_hdr_range) begin
        phase_nxt = (phase_r == PH_OFF_LO) ? PH_LEN_HI : hdr_phase_t'(phase_r + 3'd1);
        case (phase_r) inside
          PH_LEN_HI, PH_LINE_HI, PH_OFF_HI: holder_nxt = s1_byte_r;
          PH_LEN_LO:  len_we  = (count_r < COUNT_W'(MAX_SEGMENTS));
          PH_LINE_LO: line_we = (count_r < COUNT_W'(MAX_SEGMENTS));
          PH_OFF_LO: begin
            off_we = (count_r < COUNT_W'(MAX_SEGMENTS));
            if (count_r >= COUNT_W'(MAX_SEGMENTS)) ovf_nxt = 1'b1;
            if (count_r < COUNT_MAX) count_nxt = count_r + 1'b1;
            if (!field_val[MORE_FLAG_BIT]) begin
              hdone_nxt  = 1'b1;
              load_req   = 1'b1;
              load_start = '0;
              load_n     = (count_nxt >= COUNT_W'(MAX_SEGMENTS)) ? CUR_W'(MAX_SEGMENTS)
                                                                 : CUR_W'(count_nxt);
            end
          end
          default: ;
        endcase
      end
    end else if (cur_r < stored_n && left_r != '0) begin
      wr_hit = ({2'b00, frame_height_r} > cur_line_r);
      if (wr_hit) begin
        o_wr_nxt   = 1'b1;
        o_addr_nxt = addr_ext[OUT_ADDR_W-1:0];
        o_data_nxt = s1_byte_r;
      end
      next_addr_nxt = next_addr_r + 1'b1;
      left_nxt      = left_r - 1'b1;
      if (left_r == 16'd1) begin
        load_req   = 1'b1;
        load_start = cur_r + 1'b1;
      end
    end

    if (load_req) begin
      if (found) begin
        cur_nxt       = CUR_W'(sel);
        left_nxt      = len_tab[sel];
        next_addr_nxt = base_sum[ADDRESS_BITS-1:0];
        cur_line_nxt  = sel_line;
      end else begin
        cur_nxt  = load_n;
        left_nxt = '0;
      end
    end

    if (pos_r != POS_MAX) pos_nxt = pos_r + 1'b1;

    // marker and overflow as updated by this byte
    o_emit     = wr_hit || s1_last_r;
    o_fend_nxt = s1_last_r && marker_nxt;
    o_ovf_nxt  = ovf_nxt;

    if (s1_last_r) begin
      pos_nxt       = '0;
      marker_nxt    = 1'b0;
      holder_nxt    = '0;
      count_nxt     = '0;
      hdone_nxt     = 1'b0;
      phase_nxt     = PH_LEN_HI;
      cur_nxt       = '0;
      left_nxt      = '0;
      next_addr_nxt = '0;
      ovf_nxt       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r   <= LINE_WIDTH_RESET;
      frame_height_r <= FRAME_HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        CFG_LINE_WIDTH:   line_width_r   <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      marker_r    <= 1'b0;
      holder_r    <= '0;
      count_r     <= '0;
      hdone_r     <= 1'b0;
      phase_r     <= PH_LEN_HI;
      cur_r       <= '0;
      left_r      <= '0;
      next_addr_r <= '0;
      ovf_r       <= 1'b0;
      cur_line_r  <= '0;
    end else if (fire) begin
      pos_r       <= pos_nxt;
      marker_r    <= marker_nxt;
      holder_r    <= holder_nxt;
      count_r     <= count_nxt;
      hdone_r     <= hdone_nxt;
      phase_r     <= phase_nxt;
      cur_r       <= cur_nxt;
      left_r      <= left_nxt;
      next_addr_r <= next_addr_nxt;
      ovf_r       <= ovf_nxt;
      cur_line_r  <= cur_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && len_we)  len_tab[wr_idx]  <= field_val;
    if (fire && line_we) line_tab[wr_idx] <= field_val[FIELD_W-1:0];
    if (fire && off_we)  off_tab[wr_idx]  <= field_val[FIELD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && o_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && o_emit) begin
      o_wr_r   <= o_wr_nxt;
      o_addr_r <= o_addr_nxt;
      o_data_r <= o_data_nxt;
      o_fend_r <= o_fend_nxt;
      o_ovf_r  <= o_ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, o_data_r, o_addr_r};
  assign out_tuser  = {o_ovf_r, o_wr_r};
  assign out_tlast  = o_fend_r;

endmodule
`default_nettype wire
